// ----- hdl/crt_pkg.sv -----
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types, codes and helpers of the CAN request retry tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crt_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 8;
  localparam logic [3:0]  LEN_MAX       = 4'd8;

  typedef enum logic [1:0] {
    OP_REQ  = 2'd0,
    OP_RX   = 2'd1,
    OP_TICK = 2'd2,
    OP_READ = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    OK_STATUS = 2'd0,
    OK_TX     = 2'd1,
    OK_RSP    = 2'd2
  } okind_e;

  typedef enum logic [3:0] {
    ST_SENT      = 4'd0,
    ST_COMPLETE  = 4'd1,
    ST_FULL      = 4'd2,
    ST_BUSY      = 4'd3,
    ST_SEND_FAIL = 4'd4,
    ST_ACCEPTED  = 4'd5,
    ST_IGNORED   = 4'd6,
    ST_NO_MATCH  = 4'd7,
    ST_READ      = 4'd8,
    ST_NOT_READY = 4'd9,
    ST_TICK_DONE = 4'd10
  } status_e;

  typedef struct packed {
    op_e          op;
    logic         tx_ready;
    logic [28:0]  fid;
    logic [3:0]   len;
    logic [63:0]  data;
    logic [28:0]  rid;
    logic [7:0]   retries;
    logic [15:0]  tmo;
    logic         ow;
    logic [2:0]   sl;
  } cmd_t;

  typedef struct packed {
    logic [28:0]  resp_id;
    logic [15:0]  timeout;
    logic [7:0]   tries;
    logic [31:0]  last_send;
    logic [28:0]  req_id;
    logic [3:0]   req_len;
    logic [63:0]  req_data;
    logic [3:0]   rsp_len;
    logic [63:0]  rsp_data;
    logic         done;
  } slot_t;

  typedef struct packed {
    okind_e       kind;
    status_e      status;
    logic [2:0]   slot;
    logic [28:0]  id;
    logic [3:0]   len;
    logic [63:0]  data;
    logic         last;
  } res_t;

  function automatic res_t mk_res(okind_e k, status_e s, logic [2:0] idx, logic [28:0] id,
                                  logic [3:0] len, logic [63:0] data, logic last);
    res_t r;
    r.kind   = k;
    r.status = s;
    r.slot   = idx;
    r.id     = id;
    r.len    = len;
    r.data   = data;
    r.last   = last;
    return r;
  endfunction

endpackage

// ----- hdl/crt_in_if.sv -----
// ----------------------------------------------------------------------------
// crt_in_if
// Request channel of the tracker: valid/ready with the input item fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface crt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        tx_ready;
  logic [28:0] frame_id;
  logic [3:0]  frame_len;
  logic [63:0] frame_data;
  logic [28:0] response_id;
  logic [7:0]  retries;
  logic [15:0] timeout_ms;
  logic        overwrite;
  logic [2:0]  slot;

  modport source (output valid, kind, tx_ready, frame_id, frame_len, frame_data,
                  response_id, retries, timeout_ms, overwrite, slot, input ready);
  modport sink   (input valid, kind, tx_ready, frame_id, frame_len, frame_data,
                  response_id, retries, timeout_ms, overwrite, slot, output ready);
endinterface

// ----- hdl/crt_out_if.sv -----
// ----------------------------------------------------------------------------
// crt_out_if
// Result channel of the tracker: valid/ready with the result item fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface crt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [3:0]  status;
  logic [2:0]  slot_index;
  logic [28:0] out_id;
  logic [3:0]  out_len;
  logic [63:0] out_data;
  logic        last;

  modport source (output valid, out_kind, status, slot_index, out_id, out_len, out_data,
                  last, input ready);
  modport sink   (input valid, out_kind, status, slot_index, out_id, out_len, out_data,
                  last, output ready);
endinterface

// ----- hdl/crt_front.sv -----
// ----------------------------------------------------------------------------
// crt_front
// Accepts requests, clamps the length and queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crt_front import crt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  cmd_t  in_cmd_i,
  output logic  cmd_valid_o,
  output cmd_t  cmd_o,
  input  logic  cmd_pop_i
);

  localparam int unsigned QDepth = 2;

  cmd_t       q_q [QDepth];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cls;
  logic       push;

  always_comb begin
    cls = in_cmd_i;
    if (in_cmd_i.len > LEN_MAX) begin
      cls.len = LEN_MAX;
    end
  end

  assign in_ready_o  = (cnt_q != 2'(QDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push) begin
      wp_d = ~wp_q;
    end
    if (cmd_pop_i && cmd_valid_o) begin
      rp_d = ~rp_q;
    end
    cnt_d = cnt_q + 2'(push) - 2'(cmd_pop_i && cmd_valid_o);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("queue overfilled");
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'(QDepth)) |-> !push) else $error("push into full queue");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !cmd_pop_i) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count lost push");

endmodule

// ----- hdl/crt_back.sv -----
// ----------------------------------------------------------------------------
// crt_back
// Slot table sequencer: search, update, sweep and compaction, one slot a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crt_back import crt_pkg::*; #(
  parameter int unsigned MaxSlots = MAX_SLOTS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cmd_valid_i,
  input  cmd_t  cmd_i,
  output logic  cmd_pop_o,
  output logic  res_valid_o,
  output res_t  res_o,
  input  logic  res_ready_i
);

  localparam int unsigned CW = $clog2(MaxSlots + 1);
  localparam int unsigned IW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_BUSY   = 7'b0001000,
    S_SHIFT  = 7'b0010000,
    S_READ   = 7'b0100000,
    S_SWEEP  = 7'b1000000
  } state_e;

  state_e          state_q, state_d, ret_q, ret_d;
  cmd_t            cmd_q;
  slot_t           slots_q [MaxSlots];
  logic [CW-1:0]   count_q, count_d, p_q, p_d, w_q, w_d, f_q, f_d, rd_idx, wr_idx, p1;
  logic            found_q, found_d;
  logic [31:0]     now_q, now_d;
  res_t            res_q, res_n;
  logic            res_valid_q, emit, can_emit, wr_en, due;
  slot_t           rd_s, wr_s, ns;
  logic [28:0]     key;

  assign can_emit    = !res_valid_q || res_ready_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign rd_s        = slots_q[rd_idx[IW-1:0]];
  assign due         = now_q > (rd_s.last_send + 32'(rd_s.timeout));
  assign p1          = p_q + CW'(1);
  assign key         = (cmd_q.op == OP_REQ) ? cmd_q.rid : cmd_q.fid;

  always_comb begin
    ns.resp_id   = cmd_q.rid;
    ns.timeout   = cmd_q.tmo;
    ns.tries     = cmd_q.retries;
    ns.last_send = cmd_q.tx_ready ? now_q : 32'd0;
    ns.req_id    = cmd_q.fid;
    ns.req_len   = cmd_q.len;
    ns.req_data  = cmd_q.data;
    ns.rsp_len   = 4'd0;
    ns.rsp_data  = 64'd0;
    ns.done      = 1'b0;
  end

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    count_d   = count_q;
    now_d     = now_q;
    p_d       = p_q;
    w_d       = w_q;
    f_d       = f_q;
    found_d   = found_q;
    rd_idx    = p_q;
    wr_en     = 1'b0;
    wr_idx    = p_q;
    wr_s      = rd_s;
    emit      = 1'b0;
    res_n     = '0;
    cmd_pop_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          p_d       = '0;
          w_d       = '0;
          case (cmd_i.op)
            OP_REQ, OP_RX: state_d = S_SEARCH;
            OP_TICK: begin
              now_d   = now_q + 32'd1;
              state_d = S_SWEEP;
            end
            default: state_d = S_READ;
          endcase
        end
      end
      S_SEARCH: begin
        if (p_q < count_q) begin
          if (rd_s.resp_id == key) begin
            found_d = 1'b1;
            f_d     = p_q;
            state_d = S_DECIDE;
          end else begin
            p_d = p1;
          end
        end else begin
          found_d = 1'b0;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        rd_idx = f_q;
        if (can_emit) begin
          state_d = S_IDLE;
          if (cmd_q.op == OP_REQ) begin
            if (!found_q && count_q == CW'(MaxSlots)) begin
              emit  = 1'b1;
              res_n = mk_res(OK_STATUS, ST_FULL, 3'd0, '0, '0, '0, 1'b1);
            end else if (!found_q || cmd_q.ow) begin
              wr_en  = 1'b1;
              wr_idx = found_q ? f_q : count_q;
              wr_s   = ns;
              if (!found_q) begin
                count_d = count_q + CW'(1);
              end
              emit = 1'b1;
              if (cmd_q.tx_ready) begin
                res_n = mk_res(OK_TX, ST_SENT, 3'(wr_idx), cmd_q.fid, cmd_q.len,
                               cmd_q.data, 1'b1);
              end else begin
                res_n = mk_res(OK_STATUS, ST_SEND_FAIL, 3'(wr_idx), '0, '0, '0, 1'b1);
              end
            end else if (rd_s.done) begin
              emit  = 1'b1;
              res_n = mk_res(OK_STATUS, ST_COMPLETE, 3'(f_q), '0, '0, '0, 1'b1);
            end else if (rd_s.tries == 8'd0) begin
              p_d     = f_q;
              ret_d   = S_BUSY;
              state_d = S_SHIFT;
            end else begin
              state_d = S_BUSY;
              if (due && cmd_q.tx_ready) begin
                emit            = 1'b1;
                res_n           = mk_res(OK_TX, ST_SENT, 3'(f_q), rd_s.req_id, rd_s.req_len,
                                         rd_s.req_data, 1'b0);
                wr_en           = 1'b1;
                wr_idx          = f_q;
                wr_s.tries      = rd_s.tries - 8'd1;
                wr_s.last_send  = now_q;
              end
            end
          end else begin
            emit = 1'b1;
            if (!found_q) begin
              res_n = mk_res(OK_STATUS, ST_NO_MATCH, 3'd0, '0, '0, '0, 1'b1);
            end else if (rd_s.done) begin
              res_n = mk_res(OK_STATUS, ST_IGNORED, 3'(f_q), '0, '0, '0, 1'b1);
            end else begin
              res_n         = mk_res(OK_RSP, ST_ACCEPTED, 3'(f_q), cmd_q.fid, cmd_q.len,
                                     cmd_q.data, 1'b1);
              wr_en         = 1'b1;
              wr_idx        = f_q;
              wr_s.done     = 1'b1;
              wr_s.rsp_len  = cmd_q.len;
              wr_s.rsp_data = cmd_q.data;
            end
          end
        end
      end
      S_BUSY: begin
        if (can_emit) begin
          emit    = 1'b1;
          res_n   = mk_res(OK_STATUS, ST_BUSY, 3'(f_q), '0, '0, '0, 1'b1);
          state_d = S_IDLE;
        end
      end
      S_SHIFT: begin
        rd_idx = p1;
        if (p1 < count_q) begin
          wr_en  = 1'b1;
          wr_idx = p_q;
          wr_s   = rd_s;
          p_d    = p1;
        end else begin
          count_d = count_q - CW'(1);
          state_d = ret_q;
        end
      end
      S_READ: begin
        rd_idx = CW'(cmd_q.sl);
        if (can_emit) begin
          emit = 1'b1;
          if ((32'(cmd_q.sl) < 32'(count_q)) && rd_s.done) begin
            res_n   = mk_res(OK_RSP, ST_READ, cmd_q.sl, rd_s.resp_id, rd_s.rsp_len,
                             rd_s.rsp_data, 1'b1);
            p_d     = CW'(cmd_q.sl);
            ret_d   = S_IDLE;
            state_d = S_SHIFT;
          end else begin
            res_n   = mk_res(OK_STATUS, ST_NOT_READY, cmd_q.sl, '0, '0, '0, 1'b1);
            state_d = S_IDLE;
          end
        end
      end
      S_SWEEP: begin
        rd_idx = p_q;
        wr_idx = w_q;
        if (p_q < count_q) begin
          if (rd_s.done) begin
            wr_en = 1'b1;
            w_d   = w_q + CW'(1);
            p_d   = p1;
          end else if (rd_s.tries == 8'd0) begin
            p_d = p1;
          end else if (due && cmd_q.tx_ready) begin
            if (can_emit) begin
              emit           = 1'b1;
              res_n          = mk_res(OK_TX, ST_SENT, 3'(w_q), rd_s.req_id, rd_s.req_len,
                                      rd_s.req_data, 1'b0);
              wr_en          = 1'b1;
              wr_s.tries     = rd_s.tries - 8'd1;
              wr_s.last_send = now_q;
              w_d            = w_q + CW'(1);
              p_d            = p1;
            end
          end else begin
            wr_en = 1'b1;
            w_d   = w_q + CW'(1);
            p_d   = p1;
          end
        end else if (can_emit) begin
          count_d = w_q;
          emit    = 1'b1;
          res_n   = mk_res(OK_STATUS, ST_TICK_DONE, 3'd0, '0, '0, '0, 1'b1);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slots_q[wr_idx[IW-1:0]] <= wr_s;
    end
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (emit) begin
      res_q <= res_n;
    end
    p_q     <= p_d;
    w_q     <= w_d;
    f_q     <= f_d;
    found_q <= found_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      count_q     <= '0;
      now_q       <= 32'd0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      count_q <= count_d;
      now_q   <= now_d;
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxSlots)) else $error("slot count above table size");
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> can_emit) else $error("result overwritten while stalled");
  a_tick_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd_i.op == OP_TICK) |=> now_q == $past(now_q) + 32'd1)
    else $error("tick did not advance clock");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == S_IDLE && cmd_valid_i)) else $error("pop outside idle");

endmodule

// ----- hdl/can_request_retry_tracker_core.sv -----
// ----------------------------------------------------------------------------
// can_request_retry_tracker_core
// Tracks outstanding CAN requests with timed resends in a compacting slot table.
// ----------------------------------------------------------------------------
// Usage: items enter on req_i (valid/ready): request, received frame, one
// millisecond tick or response read. Results leave on rsp_o (valid/ready), one
// to nine per item, the final one flagged by last.
// A two-entry command queue parts the input side from the slot sequencer, so
// up to two items are taken while the sequencer is busy.
// Sequence: a request or received frame searches the open slots one by one,
// then decides; a request that reports busy then passes the busy state. A tick
// sweeps the open slots; a read checks the named slot. Removal of a read slot,
// or of an expired one found by a request, then shifts each slot behind it
// down one place. These per-slot steps through the single table read port set
// the rate.
// Reset: slot count and millisecond counter clear, the queue and output empty.
// A stalled receiver holds the registered result; the sequencer waits at the
// next result it has to produce, and the queue fills before req_i.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module can_request_retry_tracker_core import crt_pkg::*; #(
  parameter int unsigned MaxSlots = MAX_SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  crt_in_if.sink    req_i,
  crt_out_if.source rsp_o
);

  cmd_t in_cmd, cmd;
  logic cmd_valid, cmd_pop;
  res_t res;

  assign in_cmd.op       = op_e'(req_i.kind);
  assign in_cmd.tx_ready = req_i.tx_ready;
  assign in_cmd.fid      = req_i.frame_id;
  assign in_cmd.len      = req_i.frame_len;
  assign in_cmd.data     = req_i.frame_data;
  assign in_cmd.rid      = req_i.response_id;
  assign in_cmd.retries  = req_i.retries;
  assign in_cmd.tmo      = req_i.timeout_ms;
  assign in_cmd.ow       = req_i.overwrite;
  assign in_cmd.sl       = req_i.slot;

  crt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_cmd_i    (in_cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  crt_back #(.MaxSlots(MaxSlots)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (rsp_o.valid),
    .res_o       (res),
    .res_ready_i (rsp_o.ready)
  );

  assign rsp_o.out_kind   = res.kind;
  assign rsp_o.status     = res.status;
  assign rsp_o.slot_index = res.slot;
  assign rsp_o.out_id     = res.id;
  assign rsp_o.out_len    = res.len;
  assign rsp_o.out_data   = res.data;
  assign rsp_o.last       = res.last;

endmodule

// ----- dv/crt_checker.sv -----
// ----------------------------------------------------------------------------
// crt_checker
// Watches both channels of the retry tracker, predicts every result of each
// accepted request from its own copy of the slot table and compares results
// field by field, in order, against the predicted ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crt_checker import crt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  crt_in_if    req_mon,
  crt_out_if   rsp_mon,
  output int   fail_count_o,
  output int   pending_o
);

  slot_t       table_q [MAX_SLOTS_DEF];
  int unsigned open_cnt;
  logic [31:0] now_ms;
  res_t        due_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = due_q.size();

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    fails++;
  endtask

  task automatic emit(okind_e k, status_e s, logic [2:0] idx, logic [28:0] id,
                      logic [3:0] len, logic [63:0] data);
    res_t r;
    r.kind   = k;
    r.status = s;
    r.slot   = idx;
    r.id     = id;
    r.len    = len;
    r.data   = data;
    r.last   = 1'b0;
    due_q.push_back(r);
  endtask

  task automatic drop_slot(int unsigned i);
    for (int unsigned k = i; k + 1 < open_cnt; k++) table_q[k] = table_q[k + 1];
    open_cnt--;
  endtask

  function automatic int find_resp(logic [28:0] id);
    for (int k = 0; k < open_cnt; k++) if (table_q[k].resp_id == id) return k;
    return -1;
  endfunction

  task automatic retry_slot(int unsigned i, int unsigned rep, logic txr, output bit expired);
    logic [31:0] due;
    expired = 1'b0;
    due = table_q[i].last_send + 32'(table_q[i].timeout);
    if (table_q[i].done) return;
    if (table_q[i].tries == 8'd0) begin
      expired = 1'b1;
      return;
    end
    if (now_ms > due && txr) begin
      emit(OK_TX, ST_SENT, 3'(rep), table_q[i].req_id, table_q[i].req_len,
           table_q[i].req_data);
      table_q[i].tries--;
      table_q[i].last_send = now_ms;
    end
  endtask

  task automatic predict(cmd_t c);
    int          f;
    int unsigned i, w;
    bit          gone;
    logic [3:0]  len;
    len = (c.len > LEN_MAX) ? LEN_MAX : c.len;
    case (c.op)
      OP_REQ: begin
        f = find_resp(c.rid);
        i = 0;
        if (f < 0 && open_cnt >= MAX_SLOTS_DEF) begin
          emit(OK_STATUS, ST_FULL, 3'd0, '0, '0, '0);
        end else if (f >= 0 && !c.ow && table_q[f].done) begin
          emit(OK_STATUS, ST_COMPLETE, 3'(f), '0, '0, '0);
        end else if (f >= 0 && !c.ow) begin
          retry_slot(f, f, c.tx_ready, gone);
          if (gone) drop_slot(f);
          emit(OK_STATUS, ST_BUSY, 3'(f), '0, '0, '0);
        end else begin
          if (f < 0) begin
            i = open_cnt;
            open_cnt++;
          end else begin
            i = f;
          end
          table_q[i].resp_id  = c.rid;
          table_q[i].timeout  = c.tmo;
          table_q[i].tries    = c.retries;
          table_q[i].req_id   = c.fid;
          table_q[i].req_len  = len;
          table_q[i].req_data = c.data;
          table_q[i].rsp_len  = '0;
          table_q[i].rsp_data = '0;
          table_q[i].done     = 1'b0;
          if (c.tx_ready) begin
            table_q[i].last_send = now_ms;
            emit(OK_TX, ST_SENT, 3'(i), c.fid, len, c.data);
          end else begin
            table_q[i].last_send = '0;
            emit(OK_STATUS, ST_SEND_FAIL, 3'(i), '0, '0, '0);
          end
        end
      end
      OP_RX: begin
        f = find_resp(c.fid);
        if (f < 0) begin
          emit(OK_STATUS, ST_NO_MATCH, 3'd0, '0, '0, '0);
        end else if (table_q[f].done) begin
          emit(OK_STATUS, ST_IGNORED, 3'(f), '0, '0, '0);
        end else begin
          table_q[f].done     = 1'b1;
          table_q[f].rsp_len  = len;
          table_q[f].rsp_data = c.data;
          emit(OK_RSP, ST_ACCEPTED, 3'(f), c.fid, len, c.data);
        end
      end
      OP_TICK: begin
        now_ms++;
        w = 0;
        for (int unsigned r = 0; r < open_cnt; r++) begin
          retry_slot(r, w, c.tx_ready, gone);
          if (!gone) begin
            if (w != r) table_q[w] = table_q[r];
            w++;
          end
        end
        open_cnt = w;
        emit(OK_STATUS, ST_TICK_DONE, 3'd0, '0, '0, '0);
      end
      default: begin
        if (c.sl < open_cnt && table_q[c.sl].done) begin
          emit(OK_RSP, ST_READ, c.sl, table_q[c.sl].resp_id, table_q[c.sl].rsp_len,
               table_q[c.sl].rsp_data);
          drop_slot(c.sl);
        end else begin
          emit(OK_STATUS, ST_NOT_READY, c.sl, '0, '0, '0);
        end
      end
    endcase
    due_q[due_q.size() - 1].last = 1'b1;
  endtask

  initial begin
    open_cnt = 0;
    now_ms   = '0;
    fails    = 0;
  end

  always @(posedge clk_i) begin
    cmd_t c;
    res_t w;
    if (rst_ni) begin
      if (req_mon.valid && req_mon.ready) begin
        c.op       = op_e'(req_mon.kind);
        c.tx_ready = req_mon.tx_ready;
        c.fid      = req_mon.frame_id;
        c.len      = req_mon.frame_len;
        c.data     = req_mon.frame_data;
        c.rid      = req_mon.response_id;
        c.retries  = req_mon.retries;
        c.tmo      = req_mon.timeout_ms;
        c.ow       = req_mon.overwrite;
        c.sl       = req_mon.slot;
        predict(c);
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (due_q.size() == 0) begin
          report("unexpected result kind", 64'(rsp_mon.out_kind), '0);
        end else begin
          w = due_q.pop_front();
          if (rsp_mon.out_kind !== w.kind) report("out_kind", 64'(rsp_mon.out_kind), 64'(w.kind));
          if (rsp_mon.status !== w.status) report("status", 64'(rsp_mon.status), 64'(w.status));
          if (rsp_mon.slot_index !== w.slot)
            report("slot_index", 64'(rsp_mon.slot_index), 64'(w.slot));
          if (rsp_mon.out_id !== w.id) report("out_id", 64'(rsp_mon.out_id), 64'(w.id));
          if (rsp_mon.out_len !== w.len) report("out_len", 64'(rsp_mon.out_len), 64'(w.len));
          if (rsp_mon.out_data !== w.data) report("out_data", rsp_mon.out_data, w.data);
          if (rsp_mon.last !== w.last) report("last", 64'(rsp_mon.last), 64'(w.last));
        end
      end
    end
  end

endmodule

// ----- dv/tb_can_request_retry_tracker_core.sv -----
// ----------------------------------------------------------------------------
// tb_can_request_retry_tracker_core
// Drives directed and random request, receive, tick and read traffic into the
// retry tracker with random stalls on both sides; the checker predicts and
// compares all results and this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_can_request_retry_tracker_core;
  import crt_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  bit   quiet;
  bit   hold_go;
  logic [28:0] id_pool [10];

  crt_in_if  req_if ();
  crt_out_if rsp_if ();

  can_request_retry_tracker_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  crt_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_if),
    .rsp_mon     (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  initial begin
    #2_000_000;
    $display("can_request_retry_tracker_core: mismatch");
    $finish;
  end

  function automatic cmd_t make_cmd(op_e op, logic txr, logic [28:0] fid, logic [3:0] len,
                                    logic [63:0] data, logic [28:0] rid, logic [7:0] retries,
                                    logic [15:0] tmo, logic ow, logic [2:0] sl);
    cmd_t c;
    c.op       = op;
    c.tx_ready = txr;
    c.fid      = fid;
    c.len      = len;
    c.data     = data;
    c.rid      = rid;
    c.retries  = retries;
    c.tmo      = tmo;
    c.ow       = ow;
    c.sl       = sl;
    return c;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned pick;
    c = make_cmd(OP_REQ, $urandom_range(0, 4) != 0, 29'($urandom()),
                 4'($urandom_range(0, 15)), rand64(), id_pool[$urandom_range(0, 9)],
                 8'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                 $urandom_range(0, 3) == 0, 3'($urandom_range(0, 7)));
    if ($urandom_range(0, 7) == 0) c.retries = 8'($urandom());
    if ($urandom_range(0, 7) == 0) c.tmo = 16'($urandom());
    if ($urandom_range(0, 9) == 0) c.rid = 29'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      c.op = OP_REQ;
    end else if (pick < 60) begin
      c.op = OP_RX;
      if ($urandom_range(0, 4) != 0) c.fid = id_pool[$urandom_range(0, 9)];
    end else if (pick < 85) begin
      c.op = OP_TICK;
    end else begin
      c.op = OP_READ;
    end
    return c;
  endfunction

  task automatic send(cmd_t c);
    @(negedge clk_i);
    req_if.valid       = 1'b1;
    req_if.kind        = c.op;
    req_if.tx_ready    = c.tx_ready;
    req_if.frame_id    = c.fid;
    req_if.frame_len   = c.len;
    req_if.frame_data  = c.data;
    req_if.response_id = c.rid;
    req_if.retries     = c.retries;
    req_if.timeout_ms  = c.tmo;
    req_if.overwrite   = c.ow;
    req_if.slot        = c.sl;
    do @(posedge clk_i); while (!req_if.ready);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      req_if.valid = 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  // receiver: random stall bursts, one long hold, none at the end
  initial begin
    int  idle_left;
    int  hold_left;
    bit  hold_done;
    idle_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else if (hold_go && !hold_done) begin
        hold_done    = 1'b1;
        hold_left    = 300;
        rsp_if.ready = 1'b0;
      end else if (quiet) begin
        rsp_if.ready = 1'b1;
      end else if (idle_left > 0) begin
        rsp_if.ready = 1'b0;
        idle_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        idle_left    = $urandom_range(0, 10);
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  initial begin
    logic [63:0] ones;
    ones    = '1;
    quiet   = 1'b0;
    hold_go = 1'b0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int k = 2; k < 10; k++) id_pool[k] = 29'($urandom());
    req_if.valid       = 1'b0;
    req_if.kind        = OP_REQ;
    req_if.tx_ready    = 1'b0;
    req_if.frame_id    = '0;
    req_if.frame_len   = '0;
    req_if.frame_data  = '0;
    req_if.response_id = '0;
    req_if.retries     = '0;
    req_if.timeout_ms  = '0;
    req_if.overwrite   = 1'b0;
    req_if.slot        = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send(make_cmd(OP_REQ, 1'b1, '1, 4'd8, ones, '1, 8'd1, 16'd0, 1'b0, 3'd0));
    send(make_cmd(OP_REQ, 1'b0, '0, 4'd0, '0, '0, 8'd0, '1, 1'b0, 3'd0));
    send(make_cmd(OP_RX, 1'b1, '1, 4'd15, rand64(), '0, 8'd0, 16'd0, 1'b0, 3'd0));
    send(make_cmd(OP_RX, 1'b1, '1, 4'd3, rand64(), '0, 8'd0, 16'd0, 1'b0, 3'd0));
    send(make_cmd(OP_RX, 1'b1, 29'd12345, 4'd2, rand64(), '0, 8'd0, 16'd0, 1'b0, 3'd0));
    send(make_cmd(OP_REQ, 1'b1, 29'd7, 4'd1, rand64(), '1, 8'd3, 16'd3, 1'b0, 3'd0));
    send(make_cmd(OP_READ, 1'b1, '0, 4'd0, '0, '0, 8'd0, 16'd0, 1'b0, 3'd0));
    send(make_cmd(OP_READ, 1'b1, '0, 4'd0, '0, '0, 8'd0, 16'd0, 1'b0, 3'd7));
    send(make_cmd(OP_REQ, 1'b1, 29'd9, 4'd4, rand64(), '0, 8'd2, 16'd1, 1'b0, 3'd0));
    send(make_cmd(OP_REQ, 1'b1, 29'd5, 4'd5, rand64(), 29'd5, 8'd2, 16'd0, 1'b0, 3'd0));
    send(make_cmd(OP_TICK, 1'b1, '0, 4'd0, '0, '0, 8'd0, 16'd0, 1'b0, 3'd0));
    send(make_cmd(OP_REQ, 1'b1, 29'd5, 4'd5, rand64(), 29'd5, 8'd2, 16'd0, 1'b0, 3'd0));
    send(make_cmd(OP_TICK, 1'b0, '0, 4'd0, '0, '0, 8'd0, 16'd0, 1'b0, 3'd0));
    send(make_cmd(OP_REQ, 1'b1, 29'd6, 4'd6, rand64(), 29'd5, 8'd0, 16'd2, 1'b1, 3'd0));
    for (int k = 0; k < 8; k++)
      send(make_cmd(OP_REQ, 1'b1, 29'($urandom()), 4'($urandom_range(0, 8)), rand64(),
                    29'(100 + k), 8'd0, 16'd0, 1'b0, 3'd0));
    send(make_cmd(OP_TICK, 1'b1, '0, 4'd0, '0, '0, 8'd0, 16'd0, 1'b0, 3'd0));
    send(make_cmd(OP_TICK, 1'b1, '0, 4'd0, '0, '0, 8'd0, 16'd0, 1'b0, 3'd0));
    drain();

    for (int n = 0; n < 400; n++) begin
      if (n == 120) hold_go = 1'b1;
      if (n == 200 || n == 300) drain();
      if (n == 340) quiet = 1'b1;
      send(random_cmd());
    end
    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("can_request_retry_tracker_core: match");
    end else begin
      $display("can_request_retry_tracker_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/crt_pkg.sv
hdl/crt_in_if.sv
hdl/crt_out_if.sv
hdl/crt_front.sv
hdl/crt_back.sv
hdl/can_request_retry_tracker_core.sv
dv/crt_checker.sv
dv/tb_can_request_retry_tracker_core.sv
